[sv/sdw_pkg.sv]
// Shared types and constants for the sensor data watchdog.
`default_nettype none

package sdw_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int CMD_W         = 2;
    localparam int CNT_W         = 8;
    localparam int THR_W         = 8;
    localparam int TMO_MS_W      = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    // 65535 ms * 1000 fits in 26 bits
    localparam int TMO_US_W      = 26;

    localparam logic [TMO_US_W-1:0] MS_TO_US       = TMO_US_W'(1000);
    localparam logic [TMO_US_W-1:0] TMO_MIN_US     = TMO_US_W'(1000);
    localparam logic [TMO_US_W-1:0] TMO_RESET_US   = TMO_US_W'(500000);
    localparam logic [THR_W-1:0]    THR_RESET      = THR_W'(5);
    localparam logic [CNT_W-1:0]    CNT_MAX        = {CNT_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_CHECK = 2'd0,
        CMD_PET   = 2'd1,
        CMD_STATE = 2'd2,
        CMD_FAIL  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMM_FAIL_THR = 2'd0,
        CFG_MISS_THR      = 2'd1,
        CFG_TIMEOUT_MS    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic             monitor_enable;
        logic [CNT_W-1:0] miss_count;
        logic [CNT_W-1:0] fail_count;
    } cnt_state_t;

    typedef struct packed {
        logic             hard_fault;
        logic             comm_threshold_hit;
        logic             monitoring_on;
        logic [CNT_W-1:0] miss_count;
        logic [CNT_W-1:0] fail_count;
    } result_t;

endpackage

`default_nettype wire

[sv/sdw_step.sv]
// Per-transaction state update of the watchdog: timeout compare and counters.
`default_nettype none

module sdw_step #(
    parameter int TIME_BITS = sdw_pkg::TIME_BITS_DEF
) (
    input  wire logic [sdw_pkg::CMD_W-1:0]    cmd,
    input  wire logic [TIME_BITS-1:0]         now,
    input  wire logic                         oper,
    input  wire logic [TIME_BITS-1:0]         last_pet,
    input  wire sdw_pkg::cnt_state_t          state,
    input  wire logic [sdw_pkg::THR_W-1:0]    miss_thr,
    input  wire logic [sdw_pkg::THR_W-1:0]    fail_thr,
    input  wire logic [sdw_pkg::TMO_US_W-1:0] tmo_limit_us,
    output logic      [TIME_BITS-1:0]         last_pet_next,
    output sdw_pkg::cnt_state_t               state_next,
    output sdw_pkg::result_t                  result
);
    import sdw_pkg::*;

    logic [TIME_BITS-1:0] elapsed;
    logic                 overdue;
    logic [CNT_W-1:0]     miss_bump;
    logic [CNT_W-1:0]     fail_bump;
    logic [THR_W-1:0]     miss_thr_eff;
    logic [THR_W-1:0]     fail_thr_eff;
    logic                 hard;
    logic                 hit;

    // wraps modulo 2^TIME_BITS
    assign elapsed      = now - last_pet;
    assign overdue      = elapsed > TIME_BITS'(tmo_limit_us);
    assign miss_bump    = (state.miss_count == CNT_MAX) ? CNT_MAX
                                                        : state.miss_count + CNT_W'(1);
    assign fail_bump    = (state.fail_count == CNT_MAX) ? CNT_MAX
                                                        : state.fail_count + CNT_W'(1);
    assign miss_thr_eff = (miss_thr == '0) ? THR_W'(1) : miss_thr;
    assign fail_thr_eff = (fail_thr == '0) ? THR_W'(1) : fail_thr;

    always_comb
    begin
        state_next    = state;
        last_pet_next = last_pet;
        hard          = 1'b0;
        hit           = 1'b0;
        unique case (cmd_t'(cmd))
            CMD_CHECK:
            begin
                if (state.monitor_enable && overdue)
                begin
                    if (miss_bump >= miss_thr_eff)
                    begin
                        state_next.miss_count = '0;
                        hard                  = 1'b1;
                    end
                    else
                    begin
                        state_next.miss_count = miss_bump;
                    end
                end
            end
            CMD_PET:
            begin
                last_pet_next         = now;
                state_next.miss_count = '0;
                state_next.fail_count = '0;
            end
            CMD_STATE:
            begin
                last_pet_next             = now;
                state_next.monitor_enable = oper;
                state_next.miss_count     = '0;
                state_next.fail_count     = '0;
            end
            CMD_FAIL:
            begin
                // flag stays up on every further failure until cleared
                state_next.fail_count = fail_bump;
                hit                   = fail_bump >= fail_thr_eff;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    assign result.hard_fault         = hard;
    assign result.comm_threshold_hit = hit;
    assign result.monitoring_on      = state_next.monitor_enable;
    assign result.miss_count         = state_next.miss_count;
    assign result.fail_count         = state_next.fail_count;

endmodule

`default_nettype wire

[sv/sensor_data_watchdog.sv]
// Sensor data watchdog top level: input register, state update, result register.
// An accepted transaction's result is registered; a result stall can hold it back.
// Throughput: one transaction per cycle while the result is not stalled.
// The input stalls only while both registers hold a transaction and the result is stalled.
// Reset clears the counters, the last pet time and monitoring; thresholds return
// to 5 and the timeout to 500 ms. No clearing pass is needed.
`default_nettype none

module sensor_data_watchdog #(
    parameter int TIME_BITS = sdw_pkg::TIME_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [sdw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sdw_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire logic [sdw_pkg::CMD_W-1:0]      command,
    input  wire logic [TIME_BITS-1:0]           now_us,
    input  wire logic                           operational,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic                                hard_fault,
    output logic                                comm_threshold_hit,
    output logic                                monitoring_on,
    output logic      [sdw_pkg::CNT_W-1:0]      miss_count_out,
    output logic      [sdw_pkg::CNT_W-1:0]      fail_count_out
);
    import sdw_pkg::*;

    // configuration
    logic [THR_W-1:0]     comm_fail_thr_reg;
    logic [THR_W-1:0]     miss_thr_reg;
    logic [TMO_US_W-1:0]  tmo_us_reg;
    logic [TMO_US_W-1:0]  tmo_us_next;

    // input stage
    logic                 item_valid_reg;
    logic [CMD_W-1:0]     cmd_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic                 oper_reg;

    // watchdog state
    logic [TIME_BITS-1:0] last_pet_reg;
    logic [TIME_BITS-1:0] last_pet_next;
    cnt_state_t           cnt_reg;
    cnt_state_t           cnt_next;

    // result stage
    logic                 result_valid_reg;
    result_t              result_reg;
    result_t              result_next;

    logic                 res_ready;
    logic                 item_take;
    logic                 step_fire;

    assign res_ready  = !result_valid_reg || !result_stall;
    assign item_stall = item_valid_reg && !res_ready;
    assign item_take  = item_valid && !item_stall;
    assign step_fire  = item_valid_reg && res_ready;

    // timeout converted to microseconds once, at write time
    always_comb
    begin
        tmo_us_next = TMO_US_W'(cfg_wdata) * MS_TO_US;
        if (tmo_us_next < TMO_MIN_US)
        begin
            tmo_us_next = TMO_MIN_US;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comm_fail_thr_reg <= THR_RESET;
            miss_thr_reg      <= THR_RESET;
            tmo_us_reg        <= TMO_RESET_US;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COMM_FAIL_THR: comm_fail_thr_reg <= cfg_wdata[THR_W-1:0];
                CFG_MISS_THR:      miss_thr_reg      <= cfg_wdata[THR_W-1:0];
                CFG_TIMEOUT_MS:    tmo_us_reg        <= tmo_us_next;
                default:           ;  // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_take)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (step_fire)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            cmd_reg  <= command;
            now_reg  <= now_us;
            oper_reg <= operational;
        end
    end

    sdw_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .cmd           (cmd_reg),
        .now           (now_reg),
        .oper          (oper_reg),
        .last_pet      (last_pet_reg),
        .state         (cnt_reg),
        .miss_thr      (miss_thr_reg),
        .fail_thr      (comm_fail_thr_reg),
        .tmo_limit_us  (tmo_us_reg),
        .last_pet_next (last_pet_next),
        .state_next    (cnt_next),
        .result        (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pet_reg <= '0;
            cnt_reg      <= '0;
        end
        else if (step_fire)
        begin
            last_pet_reg <= last_pet_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            result_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid       = result_valid_reg;
    assign hard_fault         = result_reg.hard_fault;
    assign comm_threshold_hit = result_reg.comm_threshold_hit;
    assign monitoring_on      = result_reg.monitoring_on;
    assign miss_count_out     = result_reg.miss_count;
    assign fail_count_out     = result_reg.fail_count;

    // a hard fault clears the miss count and only happens while monitoring
    a_fault_clears_miss: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.hard_fault
            |-> result_reg.monitoring_on && (result_reg.miss_count == '0))
        else $error("hard fault without monitoring or with a live miss count");

    a_hit_needs_failures: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.comm_threshold_hit
            |-> (result_reg.fail_count != '0) && !result_reg.hard_fault)
        else $error("failure flag with an empty failure count");

    // a blocked input stage keeps its transaction
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !res_ready |=> item_valid_reg)
        else $error("input stage dropped a stalled transaction");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> result_valid_reg && (result_reg.miss_count == cnt_reg.miss_count)
            && (result_reg.fail_count == cnt_reg.fail_count))
        else $error("result does not match the updated counters");

    a_timeout_floor: assert property (@(posedge clk) disable iff (!rst_n)
        tmo_us_reg >= TMO_MIN_US)
        else $error("timeout below its minimum");

endmodule

`default_nettype wire

[sim/tb_sensor_data_watchdog.sv]
// Self-checking testbench for the sensor data watchdog: directed table, then randomised phases.
`timescale 1ns / 100ps

module tb_sensor_data_watchdog;

    import sdw_pkg::*;

    localparam int TIME_BITS        = TIME_BITS_DEF;
    localparam int DIR_N            = 22;
    localparam int NUM_SETTINGS     = 8;
    localparam int ITEMS_PER_PHASE  = 165;
    localparam int STORM_LEN        = 300;
    localparam int HOLD_CYCLES      = 40;
    localparam int SETTLE_CYCLES    = 4;
    localparam longint LIMIT_NS     = 1_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam logic [TMO_MS_W-1:0]  TMO_RESET_MS   = 16'd500;
    localparam logic [TIME_BITS-1:0] TIME_MAX       = '1;

    typedef struct {
        cmd_t                 cmd;
        logic [TIME_BITS-1:0] t;
        logic                 op;
        bit                   fixed;
        result_t              want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  item_valid;
    logic                  item_stall;
    logic [CMD_W-1:0]      command;
    logic [TIME_BITS-1:0]  now_us;
    logic                  operational;
    logic                  result_valid;
    logic                  result_stall;
    logic                  hard_fault;
    logic                  comm_threshold_hit;
    logic                  monitoring_on;
    logic [CNT_W-1:0]      miss_count_out;
    logic [CNT_W-1:0]      fail_count_out;

    // watchdog model: configuration copy and state
    logic [THR_W-1:0]      wd_comm_thr;
    logic [THR_W-1:0]      wd_miss_thr;
    logic [TMO_MS_W-1:0]   wd_tmo_ms;
    logic [TIME_BITS-1:0]  wd_pet_time;
    logic [CNT_W-1:0]      wd_misses;
    logic [CNT_W-1:0]      wd_fails;
    logic                  wd_monitor;

    result_t               expected_results[$];
    stim_row_t             directed_rows[DIR_N];
    int                    mismatches;
    int                    items_sent;
    bit                    idle_on;
    bit                    hold_req;
    logic [TIME_BITS-1:0]  gen_now;
    logic [TIME_BITS-1:0]  gen_pet;

    sensor_data_watchdog #(
        .TIME_BITS(TIME_BITS)
    ) DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .item_valid         (item_valid),
        .item_stall         (item_stall),
        .command            (command),
        .now_us             (now_us),
        .operational        (operational),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .hard_fault         (hard_fault),
        .comm_threshold_hit (comm_threshold_hit),
        .monitoring_on      (monitoring_on),
        .miss_count_out     (miss_count_out),
        .fail_count_out     (fail_count_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t outcome(input logic hf, input logic hit, input logic mon,
                                        input logic [CNT_W-1:0] mc, input logic [CNT_W-1:0] fc);
        result_t r;
        r.hard_fault         = hf;
        r.comm_threshold_hit = hit;
        r.monitoring_on      = mon;
        r.miss_count         = mc;
        r.fail_count         = fc;
        return r;
    endfunction

    function automatic logic [TIME_BITS-1:0] timeout_in_us(input logic [TMO_MS_W-1:0] ms);
        logic [TIME_BITS-1:0] us;
        us = TIME_BITS'(ms) * TIME_BITS'(MS_TO_US);
        return (us < TIME_BITS'(TMO_MIN_US)) ? TIME_BITS'(TMO_MIN_US) : us;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

    function automatic logic [THR_W-1:0] floor_one(input logic [THR_W-1:0] thr);
        return (thr == '0) ? THR_W'(1) : thr;
    endfunction

    task automatic watchdog_predict(input cmd_t c, input logic [TIME_BITS-1:0] t,
                                    input logic op, output result_t r);
        logic [TIME_BITS-1:0] elapsed;
        r = '0;
        case (c)
            CMD_CHECK:
            begin
                elapsed = t - wd_pet_time;
                if (wd_monitor && elapsed > timeout_in_us(wd_tmo_ms))
                begin
                    wd_misses = sat_inc(wd_misses);
                    if (wd_misses >= floor_one(wd_miss_thr))
                    begin
                        wd_misses    = '0;
                        r.hard_fault = 1'b1;
                    end
                end
            end
            CMD_PET:
            begin
                wd_pet_time = t;
                wd_misses   = '0;
                wd_fails    = '0;
            end
            CMD_STATE:
            begin
                wd_monitor  = op;
                wd_misses   = '0;
                wd_fails    = '0;
                wd_pet_time = t;
            end
            default:
            begin
                // failure count is not cleared by the flag
                wd_fails = sat_inc(wd_fails);
                if (wd_fails >= floor_one(wd_comm_thr))
                    r.comm_threshold_hit = 1'b1;
            end
        endcase
        r.monitoring_on = wd_monitor;
        r.miss_count    = wd_misses;
        r.fail_count    = wd_fails;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input longint got, input longint want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // Call at a rising edge; returns at the edge that accepts the transaction.
    task automatic send_item(input cmd_t c, input logic [TIME_BITS-1:0] t, input logic op,
                             input bit fixed, input result_t fixed_res);
        int      gap;
        result_t r;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        command     <= c;
        now_us      <= t;
        operational <= op;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        watchdog_predict(c, t, op, r);
        expected_results.push_back(fixed ? fixed_res : r);
        items_sent++;
    endtask

    task automatic send(input cmd_t c, input logic [TIME_BITS-1:0] t, input logic op);
        send_item(c, t, op, 1'b0, '0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_COMM_FAIL_THR: wd_comm_thr = data[THR_W-1:0];
            CFG_MISS_THR:      wd_miss_thr = data[THR_W-1:0];
            CFG_TIMEOUT_MS:    wd_tmo_ms   = data[TMO_MS_W-1:0];
            default:           ;
        endcase
    endtask

    task automatic apply_setting(input logic [THR_W-1:0] comm, input logic [THR_W-1:0] miss,
                                 input logic [TMO_MS_W-1:0] tmo);
        write_reg(CFG_COMM_FAIL_THR, {8'($urandom), comm});
        // out-of-range index: must leave every register alone
        write_reg(CFG_UNUSED_IDX, 16'($urandom));
        write_reg(CFG_MISS_THR, {8'($urandom), miss});
        write_reg(CFG_TIMEOUT_MS, tmo);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drain();
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly arms monitoring, then checks near the timeout bound with the odd pet or failure.
    task automatic watch_sequence();
        int unsigned          tmo;
        logic [TIME_BITS-1:0] offs;
        int                   n;
        int                   r;
        tmo = 32'(timeout_in_us(wd_tmo_ms));
        if ($urandom_range(0, 9) == 0)
            gen_now = TIME_MAX - TIME_BITS'($urandom_range(0, tmo));
        else
            gen_now = gen_now + TIME_BITS'($urandom_range(0, 5000));
        send(CMD_STATE, gen_now, $urandom_range(0, 7) != 0);
        gen_pet = gen_now;
        n = $urandom_range(1, 16);
        repeat (n)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                gen_now = gen_now + TIME_BITS'($urandom_range(0, tmo));
                send(CMD_PET, gen_now, 1'($urandom));
                gen_pet = gen_now;
            end
            else if (r == 1)
            begin
                send(CMD_FAIL, gen_now, 1'($urandom));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       offs = TIME_BITS'($urandom_range(0, tmo));
                    1:       offs = TIME_BITS'(tmo);
                    2:       offs = TIME_BITS'(tmo) + TIME_BITS'(1);
                    default: offs = TIME_BITS'(tmo) + TIME_BITS'($urandom_range(1, 3 * tmo));
                endcase
                gen_now = gen_pet + offs;
                send(CMD_CHECK, gen_now, 1'($urandom));
            end
        end
    endtask

    task automatic fail_storm(input int len);
        repeat (len) send(CMD_FAIL, gen_now, 1'($urandom));
        case ($urandom_range(0, 2))
            0:
            begin
                send(CMD_PET, gen_now, 1'($urandom));
                gen_pet = gen_now;
            end
            1:
            begin
                send(CMD_STATE, gen_now, 1'($urandom));
                gen_pet = gen_now;
            end
            default: ;
        endcase
    endtask

    task automatic noise_burst();
        cmd_t                 c;
        logic [TIME_BITS-1:0] t;
        repeat ($urandom_range(1, 6))
        begin
            c = cmd_t'($urandom_range(0, 3));
            t = TIME_BITS'({$urandom, $urandom});
            send(c, t, 1'($urandom));
            gen_now = t;
            if (c == CMD_PET || c == CMD_STATE)
                gen_pet = t;
        end
    endtask

    initial
    begin : stimulus
        int i;
        int p;
        int r;
        int lim;
        int phase_end;
        logic [THR_W-1:0]    comm;
        logic [THR_W-1:0]    miss;
        logic [TMO_MS_W-1:0] tmo;

        wd_comm_thr = THR_RESET;
        wd_miss_thr = THR_RESET;
        wd_tmo_ms   = TMO_RESET_MS;
        wd_pet_time = '0;
        wd_misses   = '0;
        wd_fails    = '0;
        wd_monitor  = 1'b0;
        mismatches  = 0;
        items_sent  = 0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;

        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_wdata   <= '0;
        item_valid  <= 1'b0;
        command     <= CMD_CHECK;
        now_us      <= '0;
        operational <= 1'b0;

        directed_rows = '{
            '{CMD_CHECK, '0,           1'b0, 1'b1, outcome(1'b0, 1'b0, 1'b0, 8'd0, 8'd0)},
            '{CMD_FAIL,  TIME_MAX,     1'b0, 1'b1, outcome(1'b0, 1'b0, 1'b0, 8'd0, 8'd1)},
            '{CMD_FAIL,  '0,           1'b1, 1'b1, outcome(1'b0, 1'b0, 1'b0, 8'd0, 8'd2)},
            '{CMD_FAIL,  '0,           1'b0, 1'b1, outcome(1'b0, 1'b0, 1'b0, 8'd0, 8'd3)},
            '{CMD_FAIL,  '0,           1'b0, 1'b1, outcome(1'b0, 1'b0, 1'b0, 8'd0, 8'd4)},
            '{CMD_FAIL,  '0,           1'b0, 1'b1, outcome(1'b0, 1'b1, 1'b0, 8'd0, 8'd5)},
            '{CMD_FAIL,  '0,           1'b0, 1'b1, outcome(1'b0, 1'b1, 1'b0, 8'd0, 8'd6)},
            '{CMD_PET,   48'd100,      1'b1, 1'b1, outcome(1'b0, 1'b0, 1'b0, 8'd0, 8'd0)},
            '{CMD_STATE, 48'd1000,     1'b1, 1'b1, outcome(1'b0, 1'b0, 1'b1, 8'd0, 8'd0)},
            '{CMD_CHECK, 48'd501000,   1'b0, 1'b0, '0},
            '{CMD_CHECK, 48'd501001,   1'b0, 1'b0, '0},
            '{CMD_CHECK, 48'd600000,   1'b1, 1'b0, '0},
            '{CMD_CHECK, 48'd700000,   1'b0, 1'b0, '0},
            '{CMD_CHECK, 48'd800000,   1'b0, 1'b0, '0},
            '{CMD_CHECK, 48'd900000,   1'b0, 1'b0, '0},
            '{CMD_FAIL,  48'd900000,   1'b0, 1'b0, '0},
            '{CMD_STATE, TIME_MAX - TIME_BITS'(9), 1'b1, 1'b0, '0},
            '{CMD_CHECK, 48'd5,        1'b0, 1'b0, '0},
            '{CMD_CHECK, 48'd499991,   1'b0, 1'b0, '0},
            '{CMD_STATE, TIME_MAX,     1'b0, 1'b1, outcome(1'b0, 1'b0, 1'b0, 8'd0, 8'd0)},
            '{CMD_CHECK, {1'b1, 47'd0}, 1'b1, 1'b1, outcome(1'b0, 1'b0, 1'b0, 8'd0, 8'd0)},
            '{CMD_PET,   TIME_MAX,     1'b0, 1'b1, outcome(1'b0, 1'b0, 1'b0, 8'd0, 8'd0)}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_N; i++)
            send_item(directed_rows[i].cmd, directed_rows[i].t, directed_rows[i].op,
                      directed_rows[i].fixed, directed_rows[i].want);
        gen_now = TIME_MAX;
        gen_pet = TIME_MAX;

        for (p = 0; p < NUM_SETTINGS; p++)
        begin
            wait_drain();
            case (p)
                0:
                begin
                    comm = '0;
                    miss = '0;
                    tmo  = '0;
                end
                1:
                begin
                    comm = '1;
                    miss = '1;
                    tmo  = '1;
                end
                2:
                begin
                    comm = 8'd1;
                    miss = 8'd1;
                    tmo  = 16'd1;
                end
                3:
                begin
                    comm = 8'd3;
                    miss = 8'd2;
                    tmo  = 16'd2;
                end
                4:
                begin
                    comm = 8'($urandom_range(0, 12));
                    miss = 8'($urandom_range(0, 12));
                    tmo  = 16'($urandom_range(0, 5));
                end
                5:
                begin
                    comm = 8'($urandom_range(0, 12));
                    miss = 8'($urandom_range(0, 12));
                    tmo  = 16'($urandom);
                end
                6:
                begin
                    comm = 8'($urandom);
                    miss = 8'($urandom);
                    tmo  = 16'($urandom);
                end
                default:
                begin
                    comm = 8'($urandom_range(0, 4));
                    miss = 8'($urandom_range(0, 4));
                    tmo  = 16'($urandom_range(0, 3));
                end
            endcase
            apply_setting(comm, miss, tmo);
            idle_on = (p != 3 && p != 5);
            if (p == 3)
                hold_req = 1'b1;
            phase_end = items_sent + ITEMS_PER_PHASE;
            // drive the failure count into saturation under the highest threshold
            if (p == 1)
                fail_storm(STORM_LEN);
            while (items_sent < phase_end)
            begin
                r = $urandom_range(0, 9);
                if (r < 5)
                    watch_sequence();
                else if (r < 7)
                begin
                    lim = int'(floor_one(wd_comm_thr)) + 3;
                    if (lim > 24)
                        lim = 24;
                    fail_storm($urandom_range(1, lim));
                end
                else
                    noise_burst();
            end
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("sensor_data_watchdog: match");
        else
            $display("sensor_data_watchdog: mismatch");
        $finish;
    end

    initial
    begin : receiver
        int w;
        result_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            // long hold-off: let the block fill and stall its input
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            w = idle_on ? $urandom_range(0, 3) : 0;
            if (w != 0)
            begin
                result_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result transaction with nothing expected", 64'd0, 64'd0);
            else
            begin
                want = expected_results.pop_front();
                check_field("hard_fault", 64'(hard_fault), 64'(want.hard_fault));
                check_field("comm_threshold_hit", 64'(comm_threshold_hit),
                            64'(want.comm_threshold_hit));
                check_field("monitoring_on", 64'(monitoring_on), 64'(want.monitoring_on));
                check_field("miss_count_out", 64'(miss_count_out), 64'(want.miss_count));
                check_field("fail_count_out", 64'(fail_count_out), 64'(want.fail_count));
            end
        end
    end

    initial
    begin : run_limit
        #(LIMIT_NS);
        $display("sensor_data_watchdog: mismatch");
        $finish;
    end

endmodule

[sensor_data_watchdog.f]
sv/sdw_pkg.sv
sv/sdw_step.sv
sv/sensor_data_watchdog.sv
sim/tb_sensor_data_watchdog.sv
